### design/gha_pkg.sv
// Shared types and codes for the generational handle allocator.
`default_nettype none

package gha_pkg;

   // Request item: allocate, or free the handle given by index and generation
   typedef struct packed {
      logic        action;
      logic [7:0]  req_index;
      logic [31:0] req_generation;
   } req_item_type;

   // Result item: one per request
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  slot_index;
      logic [31:0] slot_generation;
   } rsp_item_type;

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_STALE = 2'd3;

   // Width of the index field on both channels
   localparam int INDEX_FIELD_W = 8;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_DECIDE
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;  // request transfer: latch it and start the table reads
      logic commit;   // apply the outcome and load the result register
   } gha_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_busy; // result register holds a transfer that is stalled
   } gha_stat_type;

endpackage

`default_nettype wire

### design/gha_ctrl.sv
// Controller state machine for the generational handle allocator.
`default_nettype none

module gha_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output gha_pkg::gha_cmd_type cmd,
   input  gha_pkg::gha_stat_type stat
);
   import gha_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!stat.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECIDE: begin
            cmd.commit = !stat.out_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/gha_datapath.sv
// Datapath for the generational handle allocator: slot table, free stack,
// counters and the result register.
`default_nettype none

module gha_datapath #(
   parameter int SLOTS    = 256,
   parameter int GEN_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  gha_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output gha_pkg::rsp_item_type rsp_data,
   input  gha_pkg::gha_cmd_type  cmd,
   output gha_pkg::gha_stat_type stat
);
   import gha_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > INDEX_FIELD_W) ? CNT_W : INDEX_FIELD_W;

   // Slot table entry: live mark on top of the stamped generation.
   // Entries at or above used_count are read but never used, so no clearing is needed.
   logic [GEN_BITS:0]  slot_mem [SLOTS];
   logic [IDX_W-1:0]   stack_mem [SLOTS];

   logic [GEN_BITS:0]  slot_rd_ff;
   logic [IDX_W-1:0]   stack_rd_ff;

   logic [CNT_W-1:0]    used_count_ff, used_count_in;
   logic [CNT_W-1:0]    free_depth_ff, free_depth_in;
   logic [GEN_BITS-1:0] gen_counter_ff, gen_counter_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;

   logic                 op_action_ff;
   logic [INDEX_FIELD_W-1:0] op_index_ff;
   logic [GEN_BITS-1:0]  op_gen_ff;

   logic                 slot_we;
   logic [IDX_W-1:0]     slot_wa;
   logic [GEN_BITS:0]    slot_wd;
   logic                 stack_we;
   logic [IDX_W-1:0]     stack_wa;
   logic [IDX_W-1:0]     stack_ra;
   logic [IDX_W-1:0]     slot_ra;

   // Read addresses: the slot table from the request port, the free stack at its top
   assign slot_ra  = IDX_W'(req_data.req_index);
   assign stack_ra = IDX_W'(free_depth_ff - CNT_W'(1));

   // Latch the request and read the tables
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_action_ff <= req_data.action;
         op_index_ff  <= req_data.req_index;
         op_gen_ff    <= GEN_BITS'(req_data.req_generation);
         slot_rd_ff   <= slot_mem[slot_ra];
         stack_rd_ff  <= stack_mem[stack_ra];
      end
   end

   // Table writes
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (stack_we) begin
         stack_mem[stack_wa] <= IDX_W'(op_index_ff);
      end
   end

   // Decide the outcome of the held request
   always_comb begin
      logic             pop;
      logic             fresh;
      logic [IDX_W-1:0] slot;
      logic             range_bad;
      logic             match;

      pop       = (free_depth_ff != '0);
      fresh     = (used_count_ff < CNT_W'(SLOTS));
      slot      = pop ? stack_rd_ff : IDX_W'(used_count_ff);
      range_bad = (CMP_W'(op_index_ff) >= CMP_W'(used_count_ff));
      match     = slot_rd_ff[GEN_BITS] && (slot_rd_ff[GEN_BITS-1:0] == op_gen_ff);

      used_count_in  = used_count_ff;
      free_depth_in  = free_depth_ff;
      gen_counter_in = gen_counter_ff;
      slot_we        = 1'b0;
      slot_wa        = slot;
      slot_wd        = {1'b1, gen_counter_ff};
      stack_we       = 1'b0;
      stack_wa       = IDX_W'(free_depth_ff);
      rsp_data_in.status          = STATUS_OK;
      rsp_data_in.slot_index      = op_index_ff;
      rsp_data_in.slot_generation = 32'(op_gen_ff);

      if (op_action_ff == ACT_ALLOC) begin
         if (pop || fresh) begin
            slot_we        = cmd.commit;
            gen_counter_in = gen_counter_ff + GEN_BITS'(1);
            if (pop) begin
               free_depth_in = free_depth_ff - CNT_W'(1);
            end else begin
               used_count_in = used_count_ff + CNT_W'(1);
            end
            rsp_data_in.slot_index      = INDEX_FIELD_W'(slot);
            rsp_data_in.slot_generation = 32'(gen_counter_ff);
         end else begin
            rsp_data_in.status          = STATUS_FULL;
            rsp_data_in.slot_index      = '0;
            rsp_data_in.slot_generation = '0;
         end
      end else if (range_bad) begin
         rsp_data_in.status = STATUS_RANGE;
      end else if (!match) begin
         rsp_data_in.status = STATUS_STALE;
      end else begin
         // Release the slot and push its index
         slot_we = cmd.commit;
         slot_wa = IDX_W'(op_index_ff);
         slot_wd = {1'b0, op_gen_ff};
         if (free_depth_ff < CNT_W'(SLOTS)) begin
            stack_we      = cmd.commit;
            free_depth_in = free_depth_ff + CNT_W'(1);
         end
      end
   end

   // Result register: load on commit, drop after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff  <= '0;
         free_depth_ff  <= '0;
         gen_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            used_count_ff  <= used_count_in;
            free_depth_ff  <= free_depth_in;
            gen_counter_ff <= gen_counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

endmodule

`default_nettype wire

### design/generational_handle_allocator_unit.sv
// Generational handle allocator: hands out slot handles (index, generation)
// from a LIFO free stack or from never-used slots, and checks and releases
// them on free. Every request gives exactly one result. The idle state takes
// a request, latches it and registers the table reads; the decide state then
// applies the outcome and loads the result register, waiting while a stalled
// result still holds it, and takes no request. The next request may be taken
// while the previous result still waits to be transferred. Status 0 is ok, 1
// table full, 2 index beyond the slots handed out so far, 3 stale generation
// or slot not live. The tables need no clearing pass after reset: only slots
// below the used count are ever used.
`default_nettype none

module generational_handle_allocator_unit #(
   parameter int SLOTS    = 256,
   parameter int GEN_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  gha_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output gha_pkg::rsp_item_type rsp_data
);
   import gha_pkg::*;

   gha_cmd_type  cmd;
   gha_stat_type stat;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   gha_datapath #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

### design/gha_checker.sv
// Port-level checks for the generational handle allocator, bound to the top.
`default_nettype none

module gha_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input gha_pkg::rsp_item_type rsp_data
);
   import gha_pkg::*;

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Count requests taken whose result is not yet transferred
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // One request at a time is in work
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while previous one still in work");

   // No result without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> pending_ff != 2'd0)
      else $error("result transferred with no request outstanding");

   // At most one result waits when a new request is taken
   a_take_bound: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> pending_ff == 2'd0 || pending_ff == 2'd1)
      else $error("request taken with too many results outstanding");

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/generational_handle_allocator_unit_tb.sv
// Testbench for the generational handle allocator: random and directed handle traffic.
`timescale 1ns / 100ps

module generational_handle_allocator_unit_tb;
   import gha_pkg::*;

   localparam int TABLE_SLOTS = 256;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   generational_handle_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Two copies of the allocator state: 0 tracks accepted transfers for the
   // expected results, 1 tracks the queued requests so that frees can aim at
   // live handles.
   logic [31:0] stamp_tab  [2][TABLE_SLOTS];
   logic        live_tab   [2][TABLE_SLOTS];
   logic [7:0]  free_lifo  [2][TABLE_SLOTS];
   int unsigned lifo_depth [2];
   int unsigned handed_out [2];
   logic [31:0] next_stamp [2];

   req_item_type pending_reqs[$];
   rsp_item_type expected_handles[$];
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           fail_count    = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_model(input int m);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         stamp_tab[m][i] = '0;
         live_tab[m][i]  = 1'b0;
         free_lifo[m][i] = '0;
      end
      lifo_depth[m] = 0;
      handed_out[m] = 0;
      next_stamp[m] = '0;
   endtask

   // Apply one request to state copy m and return the result it gives
   function automatic rsp_item_type apply_request(input int m, input req_item_type r);
      rsp_item_type res;
      int unsigned  slot;
      res = '0;
      if (r.action == ACT_ALLOC) begin
         if (lifo_depth[m] > 0) begin
            lifo_depth[m] = lifo_depth[m] - 1;
            slot = free_lifo[m][lifo_depth[m]];
         end else if (handed_out[m] < TABLE_SLOTS) begin
            slot = handed_out[m];
            handed_out[m] = handed_out[m] + 1;
         end else begin
            // table full: nothing changes, the counter holds
            res.status = STATUS_FULL;
            return res;
         end
         stamp_tab[m][slot]  = next_stamp[m];
         live_tab[m][slot]   = 1'b1;
         res.status          = STATUS_OK;
         res.slot_index      = 8'(slot);
         res.slot_generation = next_stamp[m];
         next_stamp[m]       = next_stamp[m] + 32'd1;
      end else begin
         res.slot_index      = r.req_index;
         res.slot_generation = r.req_generation;
         if (r.req_index >= handed_out[m]) begin
            res.status = STATUS_RANGE;
         end else if (!live_tab[m][r.req_index] ||
                      stamp_tab[m][r.req_index] != r.req_generation) begin
            res.status = STATUS_STALE;
         end else begin
            live_tab[m][r.req_index]      = 1'b0;
            free_lifo[m][lifo_depth[m]]   = r.req_index;
            lifo_depth[m]                 = lifo_depth[m] + 1;
            res.status                    = STATUS_OK;
         end
      end
      return res;
   endfunction

   function automatic req_item_type mk_req(input logic act, input logic [7:0] idx,
                                           input logic [31:0] gen);
      req_item_type r;
      r.action         = act;
      r.req_index      = idx;
      r.req_generation = gen;
      return r;
   endfunction

   // Random slot below the used count whose live mark is want_live, or -1
   function automatic int find_slot(input logic want_live);
      int unsigned start;
      int unsigned idx;
      if (handed_out[1] == 0) return -1;
      start = $urandom_range(handed_out[1] - 1);
      for (int unsigned k = 0; k < handed_out[1]; k++) begin
         idx = (start + k) % handed_out[1];
         if (live_tab[1][idx] == want_live) return int'(idx);
      end
      return -1;
   endfunction

   task automatic push_item(input req_item_type r);
      void'(apply_request(1, r));
      pending_reqs.push_back(r);
   endtask

   // Mostly well-formed allocate and free traffic, the rest broken frees and noise
   task automatic queue_random_item(input int alloc_pct);
      int           kind;
      int           slot;
      req_item_type r;
      kind = $urandom_range(99);
      if (kind < 80) begin
         slot = find_slot(1'b1);
         if (slot < 0 || $urandom_range(99) < alloc_pct)
            r = mk_req(ACT_ALLOC, 8'($urandom), $urandom);
         else
            r = mk_req(ACT_FREE, 8'(slot), stamp_tab[1][slot]);
      end else if (kind < 87) begin
         // wrong generation on a live slot
         slot = find_slot(1'b1);
         if (slot < 0)
            r = mk_req(ACT_FREE, 8'($urandom), $urandom);
         else
            r = mk_req(ACT_FREE, 8'(slot), stamp_tab[1][slot] ^ ($urandom | 32'd1));
      end else if (kind < 92) begin
         // double free of a released slot
         slot = find_slot(1'b0);
         if (slot < 0)
            r = mk_req(ACT_FREE, 8'($urandom), $urandom);
         else
            r = mk_req(ACT_FREE, 8'(slot), stamp_tab[1][slot]);
      end else if (kind < 96 && handed_out[1] < TABLE_SLOTS) begin
         // index beyond the slots handed out
         r = mk_req(ACT_FREE, 8'($urandom_range(TABLE_SLOTS - 1, handed_out[1])), $urandom);
      end else begin
         r = mk_req(1'($urandom), 8'($urandom), $urandom);
      end
      push_item(r);
   endtask

   task automatic note_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Hold until every queued request is taken and every result has come
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_handles.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: hold a stalled transfer, otherwise send or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin : watch_transfers
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_handles.push_back(apply_request(0, req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_handles.size() == 0) begin
               note_mismatch("result with no request outstanding");
            end else begin
               want = expected_handles.pop_front();
               if (rsp_data.status != want.status)
                  note_mismatch($sformatf("status got %0d want %0d",
                                          rsp_data.status, want.status));
               if (rsp_data.slot_index != want.slot_index)
                  note_mismatch($sformatf("slot_index got %0d want %0d",
                                          rsp_data.slot_index, want.slot_index));
               if (rsp_data.slot_generation != want.slot_generation)
                  note_mismatch($sformatf("slot_generation got %0h want %0h",
                                          rsp_data.slot_generation, want.slot_generation));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Stimulus
   initial begin
      clear_model(0);
      clear_model(1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 56; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         if (ph == 0) begin
            // free on an empty table, field extremes
            push_item(mk_req(ACT_FREE, 8'd0, 32'd0));
            push_item(mk_req(ACT_FREE, 8'hFF, 32'hFFFF_FFFF));
            push_item(mk_req(ACT_ALLOC, 8'hFF, 32'hFFFF_FFFF));
            push_item(mk_req(ACT_ALLOC, 8'd0, 32'd0));
            push_item(mk_req(ACT_ALLOC, 8'hA5, 32'h5A5A_A5A5));
            // stale generation, good free, then double free
            push_item(mk_req(ACT_FREE, 8'd1, 32'hFFFF_FFFF));
            push_item(mk_req(ACT_FREE, 8'd1, 32'd1));
            push_item(mk_req(ACT_FREE, 8'd1, 32'd1));
            // index equal to the used count
            push_item(mk_req(ACT_FREE, 8'd3, 32'd3));
            push_item(mk_req(ACT_FREE, 8'd0, 32'd0));
            // reuse from the free stack, newest first, then a fresh slot
            push_item(mk_req(ACT_ALLOC, 8'd0, 32'd0));
            push_item(mk_req(ACT_ALLOC, 8'd0, 32'd0));
            push_item(mk_req(ACT_ALLOC, 8'd0, 32'd0));
            // old handle of a reused slot, an index out of range, then good frees
            push_item(mk_req(ACT_FREE, 8'd0, 32'd0));
            push_item(mk_req(ACT_FREE, 8'hFF, 32'd0));
            push_item(mk_req(ACT_FREE, 8'd2, 32'd2));
            push_item(mk_req(ACT_FREE, 8'd3, 32'd5));
         end
         // mixed, then filling towards a full table, then releasing
         repeat (120) queue_random_item(60);
         repeat (200) queue_random_item(97);
         repeat (130) queue_random_item(20);
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
design/gha_pkg.sv
design/gha_ctrl.sv
design/gha_datapath.sv
design/generational_handle_allocator_unit.sv
design/gha_checker.sv
tb/generational_handle_allocator_unit_tb.sv
